>>> hw/rtl/recurring_timer_event_queue_unit_assert.svh
// assertion macros for the recurring timer event queue
// used at the end of recurring_timer_event_queue_unit, which provides clk_i and rst_ni
`ifndef RECURRING_TIMER_EVENT_QUEUE_UNIT_ASSERT_SVH
`define RECURRING_TIMER_EVENT_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define RTEQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rteq_pkg.sv
// package for the recurring timer event queue: word types, slot record, codes
// no dependencies
package rteq_pkg;

  localparam int SlotsDefault = 16;
  localparam int MaxRes       = 16;

  localparam logic [30:0] CycleLimit = 31'(1024 * 1024 * 1024);

  localparam logic [1:0] OpTick   = 2'd0;
  localparam logic [1:0] OpAdd    = 2'd1;
  localparam logic [1:0] OpDeact  = 2'd2;

  localparam logic [1:0] KindAdded = 2'd0;
  localparam logic [1:0] KindFired = 2'd1;
  localparam logic [1:0] KindLimit = 2'd2;
  localparam logic [1:0] KindError = 2'd3;

  localparam logic [1:0] ActNull = 2'd0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [30:0] delay;
    logic [15:0] proc_id;
    logic [1:0]  action;
    logic [30:0] period;
    logic [3:0]  handle;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  fired_action;
    logic [15:0] fired_pid;
    logic [3:0]  slot;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [30:0] expiry;
    logic [31:0] order;
    logic [30:0] period;
    logic [15:0] pid;
    logic [1:0]  action;
  } slot_rec_t;

endpackage

>>> hw/rtl/rteq_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module rteq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/recurring_timer_event_queue_unit.sv
// Recurring timer event queue: keeps a 31-bit cycle counter and a table of SLOTS timer
// events (expiry, pid, action, period) in one ram, with a valid flip-flop per slot. A tick
// word advances the counter and fires expired events earliest first, equal expiries in
// insertion order, up to 16 results per tick; recurring events are re-armed at now plus
// period. A tick scans the slot table sequentially through the single ram read port (one
// slot per cycle, with registered read data), then fires the best candidate and rescans
// after each firing. An add searches for the lowest free slot, one valid bit per cycle;
// a deactivate rewrites the slot's action to null. Output stalls can hold fire and flush.
// No clearing pass after reset.
// depends on rteq_pkg, rteq_ram and recurring_timer_event_queue_unit_assert.svh
module recurring_timer_event_queue_unit #(
  parameter int SLOTS = rteq_pkg::SlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rteq_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rteq_pkg::out_word_t out_word_o
);

  import rteq_pkg::*;

  `include "recurring_timer_event_queue_unit_assert.svh"

  localparam int IdxW  = $clog2(SLOTS);
  localparam int CntW  = $clog2(SLOTS + 1);
  localparam int ResW  = $clog2(MaxRes + 1);
  localparam int RecW  = $bits(slot_rec_t);

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StDispatch = 3'd1;
  localparam logic [2:0] StScan     = 3'd2;
  localparam logic [2:0] StFire     = 3'd3;
  localparam logic [2:0] StFind     = 3'd4;
  localparam logic [2:0] StDeact    = 3'd5;
  localparam logic [2:0] StFlush    = 3'd6;

  logic [2:0]       state_q, state_d;
  in_word_t         item_q, item_d;
  logic [30:0]      now_q, now_d;
  logic [31:0]      insert_q, insert_d;
  logic [SLOTS-1:0] valid_q, valid_d;
  logic [CntW-1:0]  scan_q, scan_d;
  logic             best_found_q, best_found_d;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  slot_rec_t        best_rec_q, best_rec_d;
  logic [31:0]      best_age_q, best_age_d;
  logic [ResW-1:0]  res_cnt_q, res_cnt_d;
  logic [IdxW-1:0]  fidx_q, fidx_d;
  logic [30:0]      add_exp_q, add_exp_d;
  out_word_t        pend_q, pend_d;
  logic             pend_valid_q, pend_valid_d;
  out_word_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  // shared adder: now plus one, delay or period
  logic [30:0] add_b;
  logic [31:0] sum;
  logic        sum_over;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  slot_rec_t       ram_wdata;
  logic [IdxW-1:0] ram_raddr;
  logic [RecW-1:0] ram_rdata_raw;
  slot_rec_t       ram_rdata;

  logic [IdxW-1:0] hidx;
  logic            bad_handle;
  logic [IdxW-1:0] eidx;
  logic            cand;
  logic [31:0]     cand_age;
  logic            take;
  logic            out_free;
  logic            can_emit;
  logic            res_load;
  out_word_t       res_word;
  logic            firing;
  logic            in_accept;

  assign ram_rdata = slot_rec_t'(ram_rdata_raw);

  rteq_ram #(
    .WIDTH (RecW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (RecW'(ram_wdata)),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign hidx       = IdxW'(item_q.handle);
  assign bad_handle = (9'(item_q.handle) >= 9'(SLOTS)) || !valid_q[hidx];

  assign sum      = {1'b0, now_q} + {1'b0, add_b};
  assign sum_over = sum > {1'b0, CycleLimit};

  // scan evaluates the slot whose read was issued in the previous cycle
  assign eidx     = IdxW'(scan_q - CntW'(1));
  assign cand_age = insert_q - ram_rdata.order;
  assign cand     = valid_q[eidx] && (ram_rdata.expiry <= now_q);
  assign take     = cand && (!best_found_q || (ram_rdata.expiry < best_rec_q.expiry) ||
                    ((ram_rdata.expiry == best_rec_q.expiry) && (cand_age > best_age_q)));

  assign out_free = !out_valid_q || !out_stall_i;
  assign can_emit = !pend_valid_q || out_free;

  assign ram_raddr = (state_q == StDispatch) ? hidx : IdxW'(scan_q);

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    now_d        = now_q;
    insert_d     = insert_q;
    valid_d      = valid_q;
    scan_d       = scan_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_rec_d   = best_rec_q;
    best_age_d   = best_age_q;
    res_cnt_d    = res_cnt_q;
    fidx_d       = fidx_q;
    add_exp_d    = add_exp_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    add_b        = 31'd1;
    ram_we       = 1'b0;
    ram_waddr    = best_idx_q;
    ram_wdata    = best_rec_q;
    res_load     = 1'b0;
    res_word     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          item_d  = in_word_i;
          state_d = StDispatch;
        end
      end

      StDispatch: begin
        unique case (item_q.opcode)
          OpTick: begin
            if (now_q >= CycleLimit) begin
              res_load      = 1'b1;
              res_word.kind = KindLimit;
              state_d       = StFlush;
            end else begin
              now_d        = sum[30:0];
              res_cnt_d    = '0;
              scan_d       = '0;
              best_found_d = 1'b0;
              state_d      = StScan;
            end
          end
          OpAdd: begin
            add_b = item_q.delay;
            if (sum_over) begin
              res_load      = 1'b1;
              res_word.kind = KindLimit;
              state_d       = StFlush;
            end else begin
              add_exp_d = sum[30:0];
              fidx_d    = '0;
              state_d   = StFind;
            end
          end
          OpDeact: begin
            if (bad_handle) begin
              res_load      = 1'b1;
              res_word.kind = KindError;
              state_d       = StFlush;
            end else begin
              state_d = StDeact;
            end
          end
          default: begin
            state_d = StIdle;
          end
        endcase
      end

      StScan: begin
        if (scan_q != '0 && take) begin
          best_found_d = 1'b1;
          best_idx_d   = eidx;
          best_rec_d   = ram_rdata;
          best_age_d   = cand_age;
        end
        if (scan_q == CntW'(SLOTS)) begin
          state_d = StFire;
        end else begin
          scan_d = scan_q + CntW'(1);
        end
      end

      StFire: begin
        add_b = best_rec_q.period;
        if (!best_found_q) begin
          state_d = StFlush;
        end else if (can_emit) begin
          res_word.fired_action = best_rec_q.action;
          res_word.fired_pid    = best_rec_q.pid;
          res_word.slot         = 4'(best_idx_q);
          if (best_rec_q.period != '0 && sum_over) begin
            valid_d[best_idx_q] = 1'b0;
            res_load            = 1'b1;
            res_word.kind       = KindLimit;
          end else begin
            if (best_rec_q.period != '0) begin
              ram_we           = 1'b1;
              ram_wdata.expiry = sum[30:0];
              ram_wdata.order  = insert_q;
              insert_d         = insert_q + 32'd1;
            end else begin
              valid_d[best_idx_q] = 1'b0;
            end
            res_load      = best_rec_q.action != ActNull;
            res_word.kind = KindFired;
          end
          if (res_load) begin
            res_cnt_d = res_cnt_q + ResW'(1);
          end
          // rescan the table for the next expired event
          scan_d       = '0;
          best_found_d = 1'b0;
          state_d      = (res_cnt_d == ResW'(MaxRes)) ? StFlush : StScan;
        end
      end

      StFind: begin
        if (!valid_q[fidx_q]) begin
          ram_we            = 1'b1;
          ram_waddr         = fidx_q;
          ram_wdata.expiry  = add_exp_q;
          ram_wdata.order   = insert_q;
          ram_wdata.period  = item_q.period;
          ram_wdata.pid     = item_q.proc_id;
          ram_wdata.action  = item_q.action;
          insert_d          = insert_q + 32'd1;
          valid_d[fidx_q]   = 1'b1;
          res_load          = 1'b1;
          res_word.kind     = KindAdded;
          res_word.slot     = 4'(fidx_q);
          state_d           = StFlush;
        end else if (fidx_q == IdxW'(SLOTS - 1)) begin
          res_load      = 1'b1;
          res_word.kind = KindError;
          state_d       = StFlush;
        end else begin
          fidx_d = fidx_q + IdxW'(1);
        end
      end

      StDeact: begin
        ram_we           = 1'b1;
        ram_waddr        = hidx;
        ram_wdata        = ram_rdata;
        ram_wdata.action = ActNull;
        state_d          = StIdle;
      end

      StFlush: begin
        if (!pend_valid_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_d        = pend_q;
          out_d.last   = 1'b1;
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    // a new result pushes the held one out; the held one is last only at flush
    if (res_load) begin
      if (pend_valid_q) begin
        out_d       = pend_q;
        out_valid_d = 1'b1;
      end
      pend_d       = res_word;
      pend_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      now_q        <= '0;
      insert_q     <= '0;
      valid_q      <= '0;
      scan_q       <= '0;
      best_found_q <= 1'b0;
      res_cnt_q    <= '0;
      fidx_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      now_q        <= now_d;
      insert_q     <= insert_d;
      valid_q      <= valid_d;
      scan_q       <= scan_d;
      best_found_q <= best_found_d;
      res_cnt_q    <= res_cnt_d;
      fidx_q       <= fidx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    best_idx_q <= best_idx_d;
    best_rec_q <= best_rec_d;
    best_age_q <= best_age_d;
    add_exp_q  <= add_exp_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
  end

  assign in_stall_o  = state_q != StIdle;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign firing    = (state_q == StFire) && best_found_q;
  assign in_accept = in_valid_i && !in_stall_o;

  `RTEQ_ASSERT_NOW(a_now_limit, 1'b1, now_q <= CycleLimit, "cycle counter past its limit")
  `RTEQ_ASSERT_NOW(a_res_bound, 1'b1, res_cnt_q <= ResW'(MaxRes), "too many results")
  `RTEQ_ASSERT_NOW(a_fire_valid, firing, valid_q[best_idx_q], "firing a free slot")
  `RTEQ_ASSERT_NOW(a_accept_clean, in_accept, !pend_valid_q, "word accepted, result held")

endmodule
